@@ sv/lik_pkg.sv @@
// ----------------------------------------------------------------------------
// lik_pkg
// Shared types, widths, constants and tables for the leg inverse kinematics.
// ----------------------------------------------------------------------------
package lik_pkg;

    localparam int SEARCH_SAMPLES = 20;
    localparam int IDX_W          = $clog2(SEARCH_SAMPLES);
    localparam int SLIDE_LIMIT    = 6554;
    localparam int SAMP_SPAN      = 2 * SLIDE_LIMIT;
    localparam int SAMP_Q         = SAMP_SPAN / (SEARCH_SAMPLES - 1);
    localparam int SAMP_R         = SAMP_SPAN % (SEARCH_SAMPLES - 1);
    localparam int SREM_W         = $clog2(2 * (SEARCH_SAMPLES - 1));

    localparam int ANG_PI         = 205887;
    localparam int ABD_LIMIT      = 171573;
    localparam int PITCH_LIMIT    = 183500;
    localparam int KNEE_LIMIT     = 183500;
    localparam int CORDIC_STEPS   = 17;

    localparam int CW   = 56;  // cordic datapath
    localparam int MW   = 34;  // multiplier operand
    localparam int PW   = 68;  // product and accumulator
    localparam int DIVW = 46;  // dividend magnitude
    localparam int RW   = 23;  // divider remainder
    localparam int SQW  = 64;  // square root radicand

    localparam logic [2:0] CFG_HIP_X   = 3'd0;
    localparam logic [2:0] CFG_HIP_Y   = 3'd1;
    localparam logic [2:0] CFG_HIP_Z   = 3'd2;
    localparam logic [2:0] CFG_OFF_X   = 3'd3;
    localparam logic [2:0] CFG_OFF_Y   = 3'd4;
    localparam logic [2:0] CFG_OFF_Z   = 3'd5;
    localparam logic [2:0] CFG_UPPER   = 3'd6;
    localparam logic [2:0] CFG_LOWER   = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_AXIS     = 3'd1;
    localparam logic [2:0] ST_REACH    = 3'd2;
    localparam logic [2:0] ST_LIMITS   = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE, S_PREP, S_DXX, S_DZZ, S_SQR, S_HAA,
        S_OX1, S_OX2, S_DIVX, S_OZ1, S_OZ2, S_DIVZ,
        S_PX1, S_PX2, S_DIVP, S_D2A, S_D2B, S_REACH1, S_REACH2,
        S_NUM1, S_NUM2, S_DEN, S_NORM, S_SHIFT, S_SN, S_SQS,
        S_KNEE, S_ALPHA, S_BY, S_BX1, S_BX2, S_BETA, S_CHECK,
        S_RESULT, S_EMIT
    } t_state;

    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/lik_cordic.sv @@
// ----------------------------------------------------------------------------
// lik_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module lik_cordic (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [lik_pkg::CW-1:0] i_y,
    input  logic signed [lik_pkg::CW-1:0] i_x,
    output logic                      o_done,
    output logic signed [18:0]        o_angle
);
    import lik_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_cnt;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [19:0]   r_z;
    logic signed [18:0]   r_angle;

    logic signed [CW-1:0] xs, ys, n_x, n_y;
    logic signed [19:0]   n_z, tab;

    always_comb begin
        xs  = r_x >>> r_cnt;
        ys  = r_y >>> r_cnt;
        tab = 20'(signed'({1'b0, atan_entry(r_cnt)}));
        if (r_y > 0) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + tab;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - tab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_x == 0 && i_y == 0) begin
                    r_done  <= 1'b1;
                    r_angle <= '0;
                end else begin
                    r_busy <= 1'b1;
                    if (i_x < 0) begin
                        r_z <= (i_y >= 0) ? 20'(ANG_PI) : -20'(ANG_PI);
                        r_x <= -i_x;
                        r_y <= -i_y;
                    end else begin
                        r_z <= '0;
                        r_x <= i_x;
                        r_y <= i_y;
                    end
                end
            end else if (r_busy) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_z   <= n_z;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (n_z > 20'(ANG_PI)) begin
                        r_angle <= 19'(ANG_PI);
                    end else if (n_z < -20'(ANG_PI)) begin
                        r_angle <= -19'(ANG_PI);
                    end else begin
                        r_angle <= n_z[18:0];
                    end
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

@@ sv/lik_isqrt.sv @@
// ----------------------------------------------------------------------------
// lik_isqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module lik_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [lik_pkg::SQW-1:0]  i_val,
    output logic                     o_done,
    output logic [31:0]              o_root
);
    import lik_pkg::*;

    logic           r_busy;
    logic           r_done;
    logic [4:0]     r_cnt;
    logic [SQW-1:0] r_v;
    logic [SQW-1:0] r_r;
    logic [SQW-1:0] r_b;
    logic [31:0]    r_root;

    logic [SQW-1:0] trial, n_v, n_r;

    always_comb begin
        trial = r_r + r_b;
        if (r_v >= trial) begin
            n_v = r_v - trial;
            n_r = (r_r >> 1) + r_b;
        end else begin
            n_v = r_v;
            n_r = r_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_val;
                r_r    <= '0;
                r_b    <= SQW'(1) << (SQW - 2);
            end else if (r_busy) begin
                r_v   <= n_v;
                r_r   <= n_r;
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(SQW / 2 - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_root <= n_r[31:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ sv/leg_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// leg_inverse_kinematics
// Leg IK with prismatic slide: abduction, hip pitch and knee from a foot target,
// with an optional search over sampled slide positions.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  in       input      i_in_valid / o_in_ready     cmd, foot xyz, slide request
//  out      output     o_out_valid / i_out_ready   slide, three angles, status
//  cfg      input      i_cfg_we                    i_cfg_index, i_cfg_data
//
//  A solve uses the bit-serial divider (three divisions of 46 steps), two
//  32-step square roots and four 17-step CORDIC passes; its products all come
//  from one shared multiplier. Search mode adds twenty more solves when the
//  requested slide fails. Input is taken only when the sequencer is idle;
//  a finished result waits in the output register while the next item runs.
//  Synchronous active-low reset restores the register defaults.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic signed [18:0] i_foot_x,
    input  logic signed [18:0] i_foot_y,
    input  logic signed [18:0] i_foot_z,
    input  logic signed [15:0] i_slide_request,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_slide_used,
    output logic signed [18:0] o_abduction_angle,
    output logic signed [19:0] o_pitch_angle,
    output logic signed [18:0] o_knee_angle,
    output logic [2:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [18:0]        i_cfg_data
);
    import lik_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic signed [18:0] r_hox, r_hoy, r_hoz;
    logic signed [15:0] r_pox, r_poy, r_poz;
    logic [17:0]        r_l1, r_l2;

    // item
    logic               r_search;
    logic signed [18:0] r_fx, r_fy, r_fz;
    logic signed [15:0] r_req;
    logic               r_phase;
    logic [IDX_W-1:0]   r_idx;
    logic [SREM_W-1:0]  r_srem;
    logic signed [15:0] r_slide;

    // solve datapath
    logic                 r_busy;
    logic [5:0]           r_cnt;
    logic signed [PW-1:0] r_acc;
    logic signed [21:0]   r_dx, r_dz, r_py;
    logic [21:0]          r_r;
    logic signed [22:0]   r_hx, r_hz;
    logic signed [23:0]   r_px;
    logic signed [47:0]   r_d2, r_num;
    logic [36:0]          r_dn;
    logic [47:0]          r_mg;
    logic signed [31:0]   r_ns;
    logic [30:0]          r_sn;
    logic signed [CW-1:0] r_by;
    logic signed [18:0]   r_abd, r_knee, r_alpha;
    logic signed [19:0]   r_pitch;
    logic [2:0]           r_stat;

    // divider
    logic [DIVW-1:0] r_dq;
    logic [RW-1:0]   r_drem;
    logic            r_dneg;

    // best candidate, also final answer
    logic               r_bvalid;
    logic [16:0]        r_berr;
    logic signed [15:0] r_bslide;
    logic signed [18:0] r_babd, r_bknee;
    logic signed [19:0] r_bpitch;
    logic [2:0]         r_bstat;

    // output register
    logic               r_ovalid;
    logic signed [15:0] r_oslide;
    logic signed [18:0] r_oabd, r_oknee;
    logic signed [19:0] r_opitch;
    logic [2:0]         r_ostat;

    // shared units
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic                 c_start, c_done;
    logic signed [CW-1:0] c_y, c_x;
    logic signed [18:0]   c_angle;
    logic                 s_start, s_done;
    logic [SQW-1:0]       s_val;
    logic [31:0]          s_root;

    logic signed [21:0]   p_dx, p_dz, p_py;
    logic [RW-1:0]        div_tmp, div_rem_n;
    logic                 div_ge;
    logic [DIVW-1:0]      div_q_n;
    logic signed [DIVW:0] div_res;
    logic                 div_last;
    logic [PW-1:0]        acc_mag;
    logic signed [17:0]   serr;
    logic [16:0]          err_mag;
    logic                 out_free;
    logic                 last_sample;
    logic [SREM_W:0]      srem_sum;
    logic [47:0]          mg_clamp;
    logic signed [18:0]   beta;
    logic                 reach_fail;

    assign p_dx = 22'(r_fx) - 22'(r_hox) - 22'(r_slide);
    assign p_dz = 22'(r_fz) - 22'(r_hoz);
    assign p_py = 22'(r_fy) - 22'(r_hoy) - 22'(r_poy);

    assign mul_p = mul_a * mul_b;

    assign div_tmp   = {r_drem[RW-2:0], r_dq[DIVW-1]};
    assign div_ge    = div_tmp >= RW'(r_r);
    assign div_rem_n = div_ge ? div_tmp - RW'(r_r) : div_tmp;
    assign div_q_n   = {r_dq[DIVW-2:0], div_ge};
    assign div_res   = r_dneg ? -$signed({1'b0, div_q_n}) : $signed({1'b0, div_q_n});
    assign div_last  = r_busy && (r_cnt == 6'(DIVW - 1));
    assign acc_mag   = r_acc[PW-1] ? PW'(-r_acc) : PW'(r_acc);

    assign serr        = 18'(r_slide) - 18'(r_req);
    assign err_mag     = serr[17] ? 17'(-serr) : 17'(serr);
    assign out_free    = !r_ovalid || i_out_ready;
    assign last_sample = r_idx == IDX_W'(SEARCH_SAMPLES - 1);
    assign srem_sum    = (SREM_W + 1)'(r_srem) + (SREM_W + 1)'(SAMP_R);
    assign mg_clamp    = (r_mg > 48'(r_dn)) ? 48'(r_dn) : r_mg;
    assign beta        = (c_angle < 0) ? 19'sd0 : c_angle;
    assign reach_fail  = PW'(r_d2) > r_acc || PW'(r_d2) < mul_p;

    lik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_y     (c_y),
        .i_x     (c_x),
        .o_done  (c_done),
        .o_angle (c_angle)
    );

    lik_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_val   (s_val),
        .o_done  (s_done),
        .o_root  (s_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_PREP;
            S_PREP:   n_state = (p_dx == 0 && p_dz == 0) ? S_RESULT : S_DXX;
            S_DXX:    n_state = S_DZZ;
            S_DZZ:    n_state = S_SQR;
            S_SQR:    if (s_done) n_state = S_HAA;
            S_HAA:    if (c_done) n_state = S_OX1;
            S_OX1:    n_state = S_OX2;
            S_OX2:    n_state = S_DIVX;
            S_DIVX:   if (div_last) n_state = S_OZ1;
            S_OZ1:    n_state = S_OZ2;
            S_OZ2:    n_state = S_DIVZ;
            S_DIVZ:   if (div_last) n_state = S_PX1;
            S_PX1:    n_state = S_PX2;
            S_PX2:    n_state = S_DIVP;
            S_DIVP:   if (div_last) n_state = S_D2A;
            S_D2A:    n_state = S_D2B;
            S_D2B:    n_state = S_REACH1;
            S_REACH1: n_state = S_REACH2;
            S_REACH2: begin
                if (reach_fail) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_NUM1;
                end
            end
            S_NUM1:   n_state = S_NUM2;
            S_NUM2:   n_state = S_DEN;
            S_DEN:    n_state = S_NORM;
            S_NORM:   n_state = S_SHIFT;
            S_SHIFT:  if (r_dn < 37'h0_8000_0000) n_state = S_SN;
            S_SN:     n_state = S_SQS;
            S_SQS:    if (s_done) n_state = S_KNEE;
            S_KNEE:   if (c_done) n_state = S_ALPHA;
            S_ALPHA:  if (c_done) n_state = S_BY;
            S_BY:     n_state = S_BX1;
            S_BX1:    n_state = S_BX2;
            S_BX2:    n_state = S_BETA;
            S_BETA:   if (c_done) n_state = S_CHECK;
            S_CHECK:  n_state = S_RESULT;
            S_RESULT: begin
                if (!r_phase) begin
                    n_state = (!r_search || r_stat == ST_OK) ? S_EMIT : S_PREP;
                end else begin
                    n_state = last_sample ? S_EMIT : S_PREP;
                end
            end
            S_EMIT:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // unit controls and operand selection
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        c_start = 1'b0;
        c_y     = '0;
        c_x     = '0;
        s_start = 1'b0;
        s_val   = r_acc[SQW-1:0];
        case (r_state)
            S_DXX:    begin mul_a = MW'(r_dx);  mul_b = MW'(r_dx); end
            S_DZZ:    begin mul_a = MW'(r_dz);  mul_b = MW'(r_dz); end
            S_OX1:    begin mul_a = MW'(r_pox); mul_b = MW'(r_dx); end
            S_OX2:    begin mul_a = MW'(r_poz); mul_b = MW'(r_dz); end
            S_OZ1:    begin mul_a = MW'(r_poz); mul_b = MW'(r_dx); end
            S_OZ2:    begin mul_a = MW'(r_pox); mul_b = MW'(r_dz); end
            S_PX1:    begin mul_a = MW'(r_hx);  mul_b = MW'(r_dx); end
            S_PX2:    begin mul_a = MW'(r_hz);  mul_b = MW'(r_dz); end
            S_D2A:    begin mul_a = MW'(r_px);  mul_b = MW'(r_px); end
            S_D2B:    begin mul_a = MW'(r_py);  mul_b = MW'(r_py); end
            S_REACH1: begin
                mul_a = MW'(20'(r_l1) + 20'(r_l2));
                mul_b = MW'(20'(r_l1) + 20'(r_l2));
            end
            S_REACH2: begin
                mul_a = MW'(20'(r_l1) - 20'(r_l2));
                mul_b = MW'(20'(r_l1) - 20'(r_l2));
            end
            S_NUM1:   begin mul_a = MW'(r_l1); mul_b = MW'(r_l1); end
            S_NUM2:   begin mul_a = MW'(r_l2); mul_b = MW'(r_l2); end
            S_DEN:    begin mul_a = MW'(r_l1); mul_b = MW'(r_l2); end
            S_SN: begin
                mul_a = MW'(r_dn[31:0] - r_mg[31:0]);
                mul_b = MW'(r_dn[31:0] + r_mg[31:0]);
            end
            S_BY:     begin mul_a = MW'(r_l2); mul_b = MW'(r_sn); end
            S_BX1:    begin mul_a = MW'(r_l1); mul_b = MW'(r_dn[30:0]); end
            S_BX2:    begin mul_a = MW'(r_l2); mul_b = MW'(r_ns); end
            S_SQR, S_SQS: s_start = !r_busy;
            S_HAA: begin
                c_start = !r_busy;
                c_y     = CW'(r_dz);
                c_x     = CW'(r_dx);
            end
            S_KNEE: begin
                c_start = !r_busy;
                c_y     = CW'(r_sn);
                c_x     = CW'(r_ns);
            end
            S_ALPHA: begin
                c_start = !r_busy;
                c_y     = CW'(r_py);
                c_x     = CW'(r_px);
            end
            S_BETA: begin
                c_start = !r_busy;
                c_y     = r_by;
                c_x     = CW'(r_acc);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_hox    <= 19'sd71211;
            r_hoy    <= -19'sd51749;
            r_hoz    <= 19'sd20965;
            r_pox    <= -16'sd1527;
            r_poy    <= -16'sd3604;
            r_poz    <= 16'sd1796;
            r_l1     <= 18'd13107;
            r_l2     <= 18'd19627;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HIP_X: r_hox <= i_cfg_data;
                    CFG_HIP_Y: r_hoy <= i_cfg_data;
                    CFG_HIP_Z: r_hoz <= i_cfg_data;
                    CFG_OFF_X: r_pox <= i_cfg_data[15:0];
                    CFG_OFF_Y: r_poy <= i_cfg_data[15:0];
                    CFG_OFF_Z: r_poz <= i_cfg_data[15:0];
                    CFG_UPPER: r_l1  <= i_cfg_data[17:0];
                    CFG_LOWER: r_l2  <= i_cfg_data[17:0];
                    default: ;
                endcase
            end

            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_search <= i_cmd;
                        r_fx     <= i_foot_x;
                        r_fy     <= i_foot_y;
                        r_fz     <= i_foot_z;
                        r_req    <= i_slide_request;
                        r_slide  <= i_slide_request;
                        r_phase  <= 1'b0;
                    end
                end
                S_PREP: begin
                    r_dx    <= p_dx;
                    r_dz    <= p_dz;
                    r_py    <= p_py;
                    r_abd   <= '0;
                    r_pitch <= '0;
                    r_knee  <= '0;
                    r_stat  <= ST_AXIS;
                end
                S_REACH1: begin
                    r_d2  <= r_acc[47:0];
                    r_acc <= mul_p;
                end
                S_DXX, S_NUM1, S_BX1:           r_acc <= mul_p;
                S_DZZ, S_OX2, S_D2B, S_NUM2:    r_acc <= r_acc + mul_p;
                S_OX1, S_OZ1, S_PX1:            r_acc <= mul_p;
                S_OZ2, S_PX2, S_BX2:            r_acc <= r_acc - mul_p;
                S_D2A:                          r_acc <= mul_p;
                S_REACH2: begin
                    r_stat <= ST_REACH;
                    if (reach_fail) begin
                        r_abd <= '0;
                    end
                end
                S_SQR, S_SQS, S_HAA, S_KNEE, S_ALPHA, S_BETA: begin
                    if (!r_busy) begin
                        r_busy <= 1'b1;
                    end else if ((r_state == S_SQR || r_state == S_SQS) ? s_done : c_done) begin
                        r_busy <= 1'b0;
                        case (r_state)
                            S_SQR:   r_r     <= s_root[21:0];
                            S_SQS:   r_sn    <= s_root[30:0];
                            S_HAA:   r_abd   <= c_angle;
                            S_KNEE:  r_knee  <= -beta;
                            S_ALPHA: r_alpha <= c_angle;
                            default: r_pitch <= 20'(r_alpha) - 20'(beta);
                        endcase
                    end
                end
                S_DIVX, S_DIVZ, S_DIVP: begin
                    if (!r_busy) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                        r_dq   <= acc_mag[DIVW-1:0];
                        r_drem <= '0;
                        r_dneg <= r_acc[PW-1];
                    end else begin
                        r_dq   <= div_q_n;
                        r_drem <= div_rem_n;
                        r_cnt  <= r_cnt + 6'd1;
                        if (div_last) begin
                            r_busy <= 1'b0;
                            case (r_state)
                                S_DIVX:  r_hx <= 23'(r_dx) - 23'(div_res);
                                S_DIVZ:  r_hz <= 23'(r_dz) - 23'(div_res);
                                default: r_px <= 24'(div_res);
                            endcase
                        end
                    end
                end
                S_DEN: begin
                    r_num <= 48'(r_acc - PW'(r_d2));
                    r_acc <= mul_p;
                end
                S_NORM: begin
                    r_dn <= {r_acc[35:0], 1'b0};
                    r_mg <= r_num[47] ? 48'(-r_num) : 48'(r_num);
                end
                S_SHIFT: begin
                    if (r_dn >= 37'h0_8000_0000) begin
                        r_dn <= r_dn >> 1;
                        r_mg <= r_mg >> 1;
                    end else begin
                        r_mg <= mg_clamp;
                        r_ns <= r_num[47] ? -32'(mg_clamp) : 32'(mg_clamp);
                    end
                end
                S_SN:  r_acc <= mul_p;
                S_BY:  r_by  <= CW'(mul_p);
                S_CHECK: begin
                    if (r_slide < -16'(SLIDE_LIMIT) || r_slide > 16'(SLIDE_LIMIT) ||
                        r_abd < -19'(ABD_LIMIT) || r_abd > 19'(ABD_LIMIT) ||
                        r_pitch < -20'(PITCH_LIMIT) || r_pitch > 20'(PITCH_LIMIT) ||
                        r_knee < -19'(KNEE_LIMIT)) begin
                        r_stat <= ST_LIMITS;
                    end else begin
                        r_stat <= ST_OK;
                    end
                end
                S_RESULT: begin
                    if (!r_phase) begin
                        if (!r_search || r_stat == ST_OK) begin
                            r_bslide <= r_slide;
                            r_babd   <= r_abd;
                            r_bpitch <= r_pitch;
                            r_bknee  <= r_knee;
                            r_bstat  <= r_stat;
                        end else begin
                            r_phase  <= 1'b1;
                            r_idx    <= '0;
                            r_srem   <= '0;
                            r_slide  <= -16'(SLIDE_LIMIT);
                            r_bvalid <= 1'b0;
                            r_bslide <= '0;
                            r_babd   <= '0;
                            r_bpitch <= '0;
                            r_bknee  <= '0;
                            r_bstat  <= ST_NONE;
                        end
                    end else begin
                        if (r_stat == ST_OK && (!r_bvalid || err_mag < r_berr)) begin
                            r_bvalid <= 1'b1;
                            r_berr   <= err_mag;
                            r_bslide <= r_slide;
                            r_babd   <= r_abd;
                            r_bpitch <= r_pitch;
                            r_bknee  <= r_knee;
                            r_bstat  <= ST_OK;
                        end
                        r_idx <= r_idx + IDX_W'(1);
                        if (srem_sum >= (SREM_W + 1)'(SEARCH_SAMPLES - 1)) begin
                            r_srem  <= SREM_W'(srem_sum - (SREM_W + 1)'(SEARCH_SAMPLES - 1));
                            r_slide <= r_slide + 16'(SAMP_Q + 1);
                        end else begin
                            r_srem  <= SREM_W'(srem_sum);
                            r_slide <= r_slide + 16'(SAMP_Q);
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_oslide <= r_bslide;
                        r_oabd   <= r_babd;
                        r_opitch <= r_bpitch;
                        r_oknee  <= r_bknee;
                        r_ostat  <= r_bstat;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_ready        = r_state == S_IDLE;
    assign o_out_valid       = r_ovalid;
    assign o_slide_used      = r_oslide;
    assign o_abduction_angle = r_oabd;
    assign o_pitch_angle     = r_opitch;
    assign o_knee_angle      = r_oknee;
    assign o_status          = r_ostat;

endmodule

@@ sim/lik_checker.sv @@
// ----------------------------------------------------------------------------
// lik_checker
// Watches the input, output and register ports of leg_inverse_kinematics,
// predicts the joint solution of every accepted input transfer and compares
// each output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lik_checker
    import lik_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_cmd,
    input  logic signed [18:0] i_foot_x,
    input  logic signed [18:0] i_foot_y,
    input  logic signed [18:0] i_foot_z,
    input  logic signed [15:0] i_slide_request,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_slide_used,
    input  logic signed [18:0] i_abduction_angle,
    input  logic signed [19:0] i_pitch_angle,
    input  logic signed [18:0] i_knee_angle,
    input  logic [2:0]         i_status,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [18:0]        i_cfg_data,
    output int                 o_pending,
    output int                 o_errors,
    output int                 o_solved,
    output int                 o_searched
);

    typedef struct packed {
        logic signed [15:0] slide;
        logic signed [18:0] abd;
        logic signed [19:0] pitch;
        logic signed [18:0] knee;
        logic [2:0]         status;
    } t_joint_sol;

    longint hip_x, hip_y, hip_z, off_x, off_y, off_z, len_up, len_lo;
    t_joint_sol sol_q[$];

    localparam longint ATAN_LUT [CORDIC_STEPS] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1
    };

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint vec_angle(input longint y, input longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_LUT[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_LUT[i];
            end
        end
        if (z > ANG_PI) z = ANG_PI;
        if (z < -ANG_PI) z = -ANG_PI;
        return z;
    endfunction

    function automatic longint pos_angle(input longint y, input longint x);
        longint a;
        a = vec_angle(y, x);
        return (a < 0) ? 0 : a;
    endfunction

    function automatic logic [2:0] solve_leg(input longint slide, input longint fx,
                                             input longint fy, input longint fz,
                                             output longint abd, output longint pitch,
                                             output longint knee);
        longint dx, dy, dz, haa, r, ox, oz, hx, hz, px, py, d2, sm, df;
        longint num, den, mag, ns, sn;
        dx = fx - (hip_x + slide);
        dy = fy - hip_y;
        dz = fz - hip_z;
        abd = 0; pitch = 0; knee = 0;
        if (dx == 0 && dz == 0) return ST_AXIS;
        haa = vec_angle(dz, dx);
        r = int_sqrt(dx * dx + dz * dz);
        ox = (off_x * dx + off_z * dz) / r;
        oz = (off_z * dx - off_x * dz) / r;
        hx = dx - ox;
        hz = dz - oz;
        py = dy - off_y;
        px = (hx * dx - hz * dz) / r;
        d2 = px * px + py * py;
        sm = len_up + len_lo;
        df = len_up - len_lo;
        if (d2 > sm * sm || d2 < df * df) return ST_REACH;
        num = len_up * len_up + len_lo * len_lo - d2;
        den = 2 * len_up * len_lo;
        mag = (num < 0) ? -num : num;
        while (den >= (64'sd1 <<< 31)) begin
            den = den >>> 1;
            mag = mag >>> 1;
        end
        if (mag > den) mag = den;
        ns = (num < 0) ? -mag : mag;
        sn = int_sqrt(longint'(den - mag) * longint'(den + mag));
        knee = -pos_angle(sn, ns);
        pitch = vec_angle(py, px) - pos_angle(len_lo * sn, len_up * den - len_lo * ns);
        abd = haa;
        if (slide < -SLIDE_LIMIT || slide > SLIDE_LIMIT || haa < -ABD_LIMIT ||
            haa > ABD_LIMIT || pitch < -PITCH_LIMIT || pitch > PITCH_LIMIT ||
            knee < -KNEE_LIMIT)
            return ST_LIMITS;
        return ST_OK;
    endfunction

    function automatic t_joint_sol predict_joints(input logic cmd, input longint fx,
                                                  input longint fy, input longint fz,
                                                  input longint req);
        t_joint_sol s;
        longint a, p, k, best, sl, err;
        logic [2:0] st;
        st = solve_leg(req, fx, fy, fz, a, p, k);
        s.slide = req[15:0]; s.abd = a[18:0]; s.pitch = p[19:0];
        s.knee = k[18:0]; s.status = st;
        if (cmd && st != ST_OK) begin
            s = '0;
            s.status = ST_NONE;
            best = -1;
            for (int i = 0; i < SEARCH_SAMPLES; i++) begin
                sl = -SLIDE_LIMIT + (2 * SLIDE_LIMIT * i) / (SEARCH_SAMPLES - 1);
                if (solve_leg(sl, fx, fy, fz, a, p, k) != ST_OK) continue;
                err = (sl > req) ? sl - req : req - sl;
                if (best < 0 || err < best) begin
                    best = err;
                    s.slide = sl[15:0]; s.abd = a[18:0]; s.pitch = p[19:0];
                    s.knee = k[18:0]; s.status = ST_OK;
                end
            end
        end
        return s;
    endfunction

    assign o_pending = sol_q.size();

    always @(posedge i_clk) begin
        t_joint_sol e;
        if (!i_rst_n) begin
            hip_x <= 71211; hip_y <= -51749; hip_z <= 20965;
            off_x <= -1527; off_y <= -3604; off_z <= 1796;
            len_up <= 13107; len_lo <= 19627;
            o_errors <= 0; o_solved <= 0; o_searched <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HIP_X: hip_x <= $signed(i_cfg_data);
                    CFG_HIP_Y: hip_y <= $signed(i_cfg_data);
                    CFG_HIP_Z: hip_z <= $signed(i_cfg_data);
                    CFG_OFF_X: off_x <= $signed(i_cfg_data[15:0]);
                    CFG_OFF_Y: off_y <= $signed(i_cfg_data[15:0]);
                    CFG_OFF_Z: off_z <= $signed(i_cfg_data[15:0]);
                    CFG_UPPER: len_up <= longint'(i_cfg_data[17:0]);
                    CFG_LOWER: len_lo <= longint'(i_cfg_data[17:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                sol_q.push_back(predict_joints(i_cmd, i_foot_x, i_foot_y, i_foot_z,
                                               i_slide_request));
                if (i_cmd) o_searched <= o_searched + 1;
                else o_solved <= o_solved + 1;
            end
            if (i_out_valid && i_out_ready) begin
                if (sol_q.size() == 0) begin
                    $error("output transfer with no prediction pending");
                    o_errors <= o_errors + 1;
                end else begin
                    e = sol_q.pop_front();
                    if (e != {i_slide_used, i_abduction_angle, i_pitch_angle,
                              i_knee_angle, i_status}) begin
                        o_errors <= o_errors + 1;
                        if (e.slide !== i_slide_used)
                            $error("slide_used exp %0d got %0d", e.slide, i_slide_used);
                        if (e.abd !== i_abduction_angle)
                            $error("abduction_angle exp %0d got %0d", e.abd,
                                   i_abduction_angle);
                        if (e.pitch !== i_pitch_angle)
                            $error("pitch_angle exp %0d got %0d", e.pitch, i_pitch_angle);
                        if (e.knee !== i_knee_angle)
                            $error("knee_angle exp %0d got %0d", e.knee, i_knee_angle);
                        if (e.status !== i_status)
                            $error("status exp %0d got %0d", e.status, i_status);
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_leg_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// tb_leg_inverse_kinematics
// Drives directed and random foot targets through leg_inverse_kinematics under
// several geometry settings and idle patterns; lik_checker predicts and checks.
// ----------------------------------------------------------------------------
module tb_leg_inverse_kinematics;
    import lik_pkg::*;

    localparam longint CYCLE_LIMIT = 8000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_cmd = 1'b0;
    logic signed [18:0] i_foot_x = '0;
    logic signed [18:0] i_foot_y = '0;
    logic signed [18:0] i_foot_z = '0;
    logic signed [15:0] i_slide_request = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_slide_used;
    logic signed [18:0] o_abduction_angle;
    logic signed [19:0] o_pitch_angle;
    logic signed [18:0] o_knee_angle;
    logic [2:0]         o_status;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [18:0]        i_cfg_data = '0;

    int     pending, errors, solved, searched;
    int     tx_idle_pct = 12, rx_idle_pct = 55;
    int     geo_x = 71211, geo_y = -51749, geo_z = 20965;
    longint cycles = 0;

    leg_inverse_kinematics uut (.*);

    lik_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_cmd,
        .i_foot_x, .i_foot_y, .i_foot_z, .i_slide_request,
        .i_out_valid(o_out_valid), .i_out_ready, .i_slide_used(o_slide_used),
        .i_abduction_angle(o_abduction_angle), .i_pitch_angle(o_pitch_angle),
        .i_knee_angle(o_knee_angle), .i_status(o_status),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_errors(errors), .o_solved(solved),
        .o_searched(searched)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** leg_inverse_kinematics: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic send_target(input logic cmd, input int fx, input int fy,
                               input int fz, input int sr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_foot_x        <= fx[18:0];
        i_foot_y        <= fy[18:0];
        i_foot_z        <= fz[18:0];
        i_slide_request <= sr[15:0];
        while (!o_in_ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results;
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[18:0];
        if (idx == CFG_HIP_X) geo_x = val;
        if (idx == CFG_HIP_Y) geo_y = val;
        if (idx == CFG_HIP_Z) geo_z = val;
        @(negedge i_clk);
    endtask

    task automatic write_geometry(input int hx, input int hy, input int hz, input int ox,
                                  input int oy, input int oz, input int l1, input int l2);
        drain_results();
        write_reg(CFG_HIP_X, hx);
        write_reg(CFG_HIP_Y, hy);
        write_reg(CFG_HIP_Z, hz);
        write_reg(CFG_OFF_X, ox);
        write_reg(CFG_OFF_Y, oy);
        write_reg(CFG_OFF_Z, oz);
        write_reg(CFG_UPPER, l1);
        write_reg(CFG_LOWER, l2);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_targets(input int n);
        int sp;
        for (int k = 0; k < n; k++) begin
            sp = $urandom_range(0, 99);
            if (sp < 70)
                send_target(1'($urandom_range(0, 1)),
                            geo_x + $signed($urandom_range(0, 50000)) - 25000,
                            geo_y + $signed($urandom_range(0, 50000)) - 25000,
                            geo_z + $signed($urandom_range(0, 50000)) - 25000,
                            $signed($urandom_range(0, 16000)) - 8000);
            else
                send_target(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                            $urandom);
        end
    endtask

    initial begin
        int k;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_target(1'b0, 71211, -51749, 20965, 0);
        send_target(1'b1, 71211, -51749, 20965, 0);
        send_target(1'b0, 74211, -76749, 22965, 0);
        send_target(1'b0, 74211, -76749, 22965, 32767);
        send_target(1'b1, 74211, -76749, 22965, -32768);
        send_target(1'b0, 74211, -76749, 22965, 6554);
        send_target(1'b0, 74211, -76749, 22965, -6554);
        send_target(1'b1, 74211, -76749, 22965, 6555);
        send_target(1'b0, 262143, 262143, 262143, 0);
        send_target(1'b1, 262143, 262143, 262143, 100);
        send_target(1'b0, -262144, -262144, -262144, -1);
        send_target(1'b1, -262144, -262144, -262144, 0);
        send_target(1'b0, 0, 0, 0, 0);
        send_target(1'b0, 262143, -262144, 0, 0);
        send_target(1'b0, 60000, -80000, 21000, 0);
        drain_results();
        random_targets(20);

        write_geometry(262143, 262143, 262143, -32768, -32768, -32768, 131072, 131072);
        send_target(1'b0, 262143, 262143, 262143, 0);
        send_target(1'b1, 200000, 150000, 262143, 0);
        random_targets(20);

        tx_idle_pct = 55;
        rx_idle_pct = 12;
        write_geometry(-262144, -262144, -262144, 32767, 32767, 32767, 1, 1);
        send_target(1'b0, -262144, -262144, -262144, 0);
        send_target(1'b1, -262143, -262144, -262144, 0);
        random_targets(20);

        // offsets cleared and equal links: target on the pitch axis
        k = $urandom_range(5000, 40000);
        write_geometry($signed($urandom_range(0, 200000)) - 100000,
                       $signed($urandom_range(0, 200000)) - 100000,
                       $signed($urandom_range(0, 200000)) - 100000, 0, 0, 0, k, k);
        send_target(1'b0, geo_x + 3000, geo_y, geo_z + 3000, 0);
        send_target(1'b1, geo_x + 3000, geo_y, geo_z + 3000, 0);
        random_targets(20);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int ph = 0; ph < 2; ph++) begin
            write_geometry($signed($urandom_range(0, 200000)) - 100000,
                           $signed($urandom_range(0, 200000)) - 100000,
                           $signed($urandom_range(0, 200000)) - 100000,
                           $signed($urandom_range(0, 8000)) - 4000,
                           $signed($urandom_range(0, 8000)) - 4000,
                           $signed($urandom_range(0, 8000)) - 4000,
                           $urandom_range(5000, 40000), $urandom_range(5000, 40000));
            random_targets(20);
        end

        drain_results();
        repeat (100) @(negedge i_clk);
        $display("Covered %0d fixed-slide and %0d slide-search targets", solved, searched);
        $display("over six geometry settings and three idle patterns, %0d mismatches",
                 errors);
        if (errors == 0 && pending == 0) begin
            $display("** leg_inverse_kinematics: PASSED **");
        end else begin
            $display("** leg_inverse_kinematics: FAILED **");
        end
        $finish;
    end

endmodule
